// ----- rtl/mpt_pkg.sv -----
// Shared types and constants for the multichannel pulse timer.
// No dependencies; every other file in rtl/ imports this package.
package mpt_pkg;

  localparam int NUM_CH    = 7;
  localparam int NUM_PING  = 3;
  localparam int LEN_W     = 17;
  localparam int STAMP_W   = 32;
  localparam int DIR_W     = 3;
  localparam int REG_IDX_W = 3;

  typedef logic [LEN_W-1:0]     len_t;
  typedef logic [STAMP_W-1:0]   stamp_t;
  typedef logic [DIR_W-1:0]     dir_code_t;
  typedef logic [REG_IDX_W-1:0] reg_addr_t;
  typedef logic [NUM_PING-1:0]  ping_vec_t;
  typedef logic [NUM_CH-1:0]    pin_vec_t;

  // configuration register map
  typedef enum logic [REG_IDX_W-1:0] {
    REG_SERVO_LONG_HIGH  = 3'd0,
    REG_SERVO_SHORT_HIGH = 3'd1,
    REG_SERVO_LOW        = 3'd2,
    REG_PING_HIGH        = 3'd3,
    REG_PING_LOW         = 3'd4,
    REG_CAMERA_HALF      = 3'd5,
    REG_SIREN_HALF       = 3'd6
  } reg_idx_t;

  localparam len_t REG_RESET [NUM_CH] = '{
    17'd200, 17'd100, 17'd100, 17'd1, 17'd4500, 17'd100000, 17'd10000
  };

  // drive direction codes
  typedef enum logic [DIR_W-1:0] {
    DIR_RIGHT    = 3'd0,
    DIR_LEFT     = 3'd1,
    DIR_FORWARD  = 3'd2,
    DIR_BACKWARD = 3'd3,
    DIR_STOP     = 3'd4
  } dir_t;

  // channel slots in the pin vector
  localparam int CH_SERVO_A = 0;
  localparam int CH_SERVO_B = 1;
  localparam int CH_PING0   = 2;
  localparam int CH_CAMERA  = 5;
  localparam int CH_SIREN   = 6;

  typedef struct packed {
    logic service;    // run the compare-and-toggle this beat
    logic force_low;  // clear the pin without touching timing state
  } chan_ctl_t;

endpackage

// ----- rtl/mpt_in_if.sv -----
// Input tick channel: valid/ready plus the tick payload.
// Depends on mpt_pkg.
interface mpt_in_if;
  import mpt_pkg::*;

  logic      valid;
  logic      ready;
  stamp_t    current_time;
  dir_code_t direction;
  logic      ping_enable;
  logic      alarm_active;
  logic      siren_switch;

  modport source (output valid, current_time, direction, ping_enable, alarm_active,
                  siren_switch, input ready);
  modport sink   (input valid, current_time, direction, ping_enable, alarm_active,
                  siren_switch, output ready);
endinterface

// ----- rtl/mpt_out_if.sv -----
// Result channel: valid/ready plus the pin levels after one tick.
// Depends on mpt_pkg.
interface mpt_out_if;
  import mpt_pkg::*;

  logic      valid;
  logic      ready;
  logic      servo_a_level;
  logic      servo_b_level;
  ping_vec_t ping_levels;
  logic      camera_level;
  logic      alarm_led;
  logic      siren_level;

  modport source (output valid, servo_a_level, servo_b_level, ping_levels, camera_level,
                  alarm_led, siren_level, input ready);
  modport sink   (input valid, servo_a_level, servo_b_level, ping_levels, camera_level,
                  alarm_led, siren_level, output ready);
endinterface

// ----- rtl/mpt_cfg_if.sv -----
// Configuration write channel: valid/ready, register index and write data.
// Depends on mpt_pkg.
interface mpt_cfg_if;
  import mpt_pkg::*;

  logic      valid;
  logic      ready;
  reg_addr_t index;
  len_t      data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/mpt_channel.sv -----
// One pulse channel: toggle stamp, phase length, next level and pin register.
// Depends on mpt_pkg.
module mpt_channel #(
  parameter int TIME_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               advance,
  input  mpt_pkg::chan_ctl_t ctl,
  input  mpt_pkg::len_t      high_len,
  input  mpt_pkg::len_t      low_len,
  input  logic [TIME_BITS-1:0] now,
  output logic               level
);
  import mpt_pkg::*;

  localparam int CMP_W = (TIME_BITS > LEN_W) ? TIME_BITS : LEN_W;

  logic [TIME_BITS-1:0] stamp_r, stamp_nxt;
  len_t                 len_r, len_nxt;
  logic                 next_high_r, next_high_nxt;
  logic                 level_r, level_nxt;
  logic [TIME_BITS-1:0] elapsed;
  logic                 fire;

  // subtraction wraps modulo 2^TIME_BITS
  assign elapsed = now - stamp_r;
  assign fire    = ctl.service && (CMP_W'(elapsed) > CMP_W'(len_r));

  always_comb begin
    stamp_nxt     = stamp_r;
    len_nxt       = len_r;
    next_high_nxt = next_high_r;
    level_nxt     = level_r;
    if (fire) begin
      stamp_nxt     = now;
      len_nxt       = next_high_r ? high_len : low_len;
      level_nxt     = next_high_r;
      next_high_nxt = ~next_high_r;
    end else if (ctl.force_low) begin
      level_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stamp_r     <= '0;
      len_r       <= '0;
      next_high_r <= 1'b0;
      level_r     <= 1'b0;
    end else if (advance) begin
      stamp_r     <= stamp_nxt;
      len_r       <= len_nxt;
      next_high_r <= next_high_nxt;
      level_r     <= level_nxt;
    end
  end

  assign level = level_r;

endmodule

// ----- rtl/multichannel_pulse_timer.sv -----
// Seven-channel pulse timer (two servos, three ping triggers, camera, siren).
// Depends on mpt_pkg, mpt_in_if, mpt_out_if, mpt_cfg_if and mpt_channel.
//
// Usage:
//  - in_bus carries one tick per beat: time stamp, drive direction, ping enable,
//    alarm flag and siren switch. Ticks may arrive back to back, one per clock, while in_bus.ready is high.
//  - out_bus returns one beat per tick: the pin levels after that tick plus the
//    alarm LED. Results come out in tick order.
//  - cfg_bus writes the seven phase length registers (index 0..6); writes to
//    index 7 are dropped. cfg_bus.ready is always high. Write only while idle.
//  - A tick accepted on in_bus is registered in the input stage; the channels
//    update and the result becomes valid when it moves into the pin registers.
//    One tick per clock passes while out_bus does not stall, set by the single
//    compare-and-toggle pass of each channel between input stage and pin registers.
//  - The pin registers double as the result register, so channel state only
//    moves when a result beat can be loaded.
//  - Stall: if out_bus.ready is low, one result waits in the output register and
//    one tick in the input stage; in_bus.ready drops only when both are full.
//  - Reset (rst_n low, synchronous): pins low, all channel timing state zero,
//    config registers back to their defaults, both stages empty.
module multichannel_pulse_timer #(
  parameter int TIME_BITS = 32
) (
  input logic clk,
  input logic rst_n,
  mpt_in_if.sink    in_bus,
  mpt_out_if.source out_bus,
  mpt_cfg_if.sink   cfg_bus
);
  import mpt_pkg::*;

  // config registers
  len_t cfg_r   [NUM_CH];
  len_t cfg_nxt [NUM_CH];

  // input stage
  logic      s1_valid_r;
  stamp_t    s1_time_r;
  dir_code_t s1_dir_r;
  logic      s1_ping_r;
  logic      s1_alarm_r;
  logic      s1_sw_r;

  // output stage (pin levels live in the channels)
  logic      out_valid_r;
  logic      alarm_led_r;

  logic      advance;
  logic      in_take;
  logic      servo_en;
  logic [TIME_BITS-1:0] now;
  chan_ctl_t ch_ctl  [NUM_CH];
  len_t      ch_high [NUM_CH];
  len_t      ch_low  [NUM_CH];
  pin_vec_t  pins;

  // ---------------- configuration ----------------
  assign cfg_bus.ready = 1'b1;

  always_comb begin
    for (int i = 0; i < NUM_CH; i++) cfg_nxt[i] = cfg_r[i];
    if (cfg_bus.valid && (cfg_bus.index <= REG_SIREN_HALF)) begin
      cfg_nxt[cfg_bus.index] = cfg_bus.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CH; i++) cfg_r[i] <= REG_RESET[i];
    end else begin
      for (int i = 0; i < NUM_CH; i++) cfg_r[i] <= cfg_nxt[i];
    end
  end

  // ---------------- handshake ----------------
  // stage 1 moves into the pin registers when the output slot frees up
  assign advance       = s1_valid_r && (!out_valid_r || out_bus.ready);
  assign in_bus.ready  = !s1_valid_r || advance;
  assign in_take       = in_bus.valid && in_bus.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take)      s1_valid_r <= 1'b1;
      else if (advance) s1_valid_r <= 1'b0;

      if (advance)            out_valid_r <= 1'b1;
      else if (out_bus.ready) out_valid_r <= 1'b0;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_time_r  <= in_bus.current_time;
      s1_dir_r   <= in_bus.direction;
      s1_ping_r  <= in_bus.ping_enable;
      s1_alarm_r <= in_bus.alarm_active;
      s1_sw_r    <= in_bus.siren_switch;
    end
    if (advance) alarm_led_r <= s1_alarm_r;
  end

  // ---------------- per-channel control ----------------
  assign now      = TIME_BITS'(s1_time_r);
  assign servo_en = s1_dir_r inside {DIR_RIGHT, DIR_LEFT, DIR_FORWARD, DIR_BACKWARD};

  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      ch_ctl[i]  = '0;
      ch_high[i] = '0;
      ch_low[i]  = '0;
    end

    // servos: stop and unused codes leave them alone
    ch_ctl[CH_SERVO_A].service = servo_en;
    ch_ctl[CH_SERVO_B].service = servo_en;
    ch_high[CH_SERVO_A] = (s1_dir_r == DIR_RIGHT || s1_dir_r == DIR_FORWARD)
                          ? cfg_r[REG_SERVO_LONG_HIGH] : cfg_r[REG_SERVO_SHORT_HIGH];
    ch_high[CH_SERVO_B] = (s1_dir_r == DIR_RIGHT || s1_dir_r == DIR_BACKWARD)
                          ? cfg_r[REG_SERVO_LONG_HIGH] : cfg_r[REG_SERVO_SHORT_HIGH];
    ch_low[CH_SERVO_A]  = cfg_r[REG_SERVO_LOW];
    ch_low[CH_SERVO_B]  = cfg_r[REG_SERVO_LOW];

    // ping triggers share one pair of lengths
    for (int p = 0; p < NUM_PING; p++) begin
      ch_ctl[CH_PING0+p].service = s1_ping_r;
      ch_high[CH_PING0+p] = cfg_r[REG_PING_HIGH];
      ch_low[CH_PING0+p]  = cfg_r[REG_PING_LOW];
    end

    // camera runs with the alarm; siren also needs the switch
    ch_ctl[CH_CAMERA].service   = s1_alarm_r;
    ch_ctl[CH_CAMERA].force_low = !s1_alarm_r;
    ch_high[CH_CAMERA] = cfg_r[REG_CAMERA_HALF];
    ch_low[CH_CAMERA]  = cfg_r[REG_CAMERA_HALF];

    ch_ctl[CH_SIREN].service   = s1_alarm_r && s1_sw_r;
    ch_ctl[CH_SIREN].force_low = !(s1_alarm_r && s1_sw_r);
    ch_high[CH_SIREN] = cfg_r[REG_SIREN_HALF];
    ch_low[CH_SIREN]  = cfg_r[REG_SIREN_HALF];
  end

  for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
    mpt_channel #(
      .TIME_BITS (TIME_BITS)
    ) u_ch (
      .clk      (clk),
      .rst_n    (rst_n),
      .advance  (advance),
      .ctl      (ch_ctl[c]),
      .high_len (ch_high[c]),
      .low_len  (ch_low[c]),
      .now      (now),
      .level    (pins[c])
    );
  end

  // ---------------- result beat ----------------
  assign out_bus.valid         = out_valid_r;
  assign out_bus.servo_a_level = pins[CH_SERVO_A];
  assign out_bus.servo_b_level = pins[CH_SERVO_B];
  assign out_bus.ping_levels   = pins[CH_PING0 +: NUM_PING];
  assign out_bus.camera_level  = pins[CH_CAMERA];
  assign out_bus.alarm_led     = alarm_led_r;
  assign out_bus.siren_level   = pins[CH_SIREN];

`ifndef SYNTH
  // camera and siren can only be high while the alarm is raised
  a_alarm_gates: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (pins[CH_CAMERA] || pins[CH_SIREN]) |-> alarm_led_r)
    else $error("camera or siren high without alarm");

  // pins only move when a tick is retired into the output slot
  a_pins_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(pins))
    else $error("pin levels changed without a retired tick");

  // an accepted tick always lands in the input stage
  a_take_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> s1_valid_r)
    else $error("accepted tick lost");
`endif

endmodule

// ----- verif/multichannel_pulse_timer_checker.sv -----
// Scoreboard for the multichannel pulse timer: watches the tick, result and
// register-write channels, predicts the pin levels and compares every result beat.
// Depends on mpt_pkg and the mpt_in_if, mpt_out_if and mpt_cfg_if interfaces.
module multichannel_pulse_timer_checker (
  input  logic clk,
  input  logic rst_n,
  mpt_in_if    in_mon,
  mpt_out_if   out_mon,
  mpt_cfg_if   cfg_mon,
  output int   fault_count,
  output int   pending_count,
  output int   checked_count
);
  import mpt_pkg::*;

  typedef struct packed {
    logic      servo_a;
    logic      servo_b;
    ping_vec_t ping;
    logic      camera;
    logic      led;
    logic      siren;
  } pin_snap_t;

  // shadow of the block: phase registers plus per-channel timing state
  len_t     phase_reg [NUM_CH];
  stamp_t   last_flip [NUM_CH];
  len_t     hold_len  [NUM_CH];
  logic     rise_next [NUM_CH];
  pin_vec_t pins;

  pin_snap_t level_q [$];
  int faults  = 0;
  int checked = 0;

  // compare-and-toggle of one channel; elapsed time wraps with the stamp width
  function automatic void flip_if_due(int ch, len_t hi_len, len_t lo_len, stamp_t now);
    stamp_t since;
    since = now - last_flip[ch];
    if (since > stamp_t'(hold_len[ch])) begin
      last_flip[ch] = now;
      if (rise_next[ch]) begin
        hold_len[ch] = hi_len;
        pins[ch]     = 1'b1;
      end else begin
        hold_len[ch] = lo_len;
        pins[ch]     = 1'b0;
      end
      rise_next[ch] = ~rise_next[ch];
    end
  endfunction

  function automatic pin_snap_t tick_levels(stamp_t now, dir_code_t dir, logic ping_on,
                                            logic alarm, logic siren_sw);
    pin_snap_t snap;
    len_t      a_high;
    len_t      b_high;
    if (dir <= DIR_BACKWARD) begin
      a_high = (dir == DIR_RIGHT || dir == DIR_FORWARD) ?
               phase_reg[REG_SERVO_LONG_HIGH] : phase_reg[REG_SERVO_SHORT_HIGH];
      b_high = (dir == DIR_RIGHT || dir == DIR_BACKWARD) ?
               phase_reg[REG_SERVO_LONG_HIGH] : phase_reg[REG_SERVO_SHORT_HIGH];
      flip_if_due(CH_SERVO_A, a_high, phase_reg[REG_SERVO_LOW], now);
      flip_if_due(CH_SERVO_B, b_high, phase_reg[REG_SERVO_LOW], now);
    end
    if (ping_on)
      for (int i = 0; i < NUM_PING; i++)
        flip_if_due(CH_PING0 + i, phase_reg[REG_PING_HIGH], phase_reg[REG_PING_LOW], now);
    // gating clears pins only; timing state keeps running where it was
    if (alarm) begin
      flip_if_due(CH_CAMERA, phase_reg[REG_CAMERA_HALF], phase_reg[REG_CAMERA_HALF], now);
      if (siren_sw)
        flip_if_due(CH_SIREN, phase_reg[REG_SIREN_HALF], phase_reg[REG_SIREN_HALF], now);
      else
        pins[CH_SIREN] = 1'b0;
    end else begin
      pins[CH_CAMERA] = 1'b0;
      pins[CH_SIREN]  = 1'b0;
    end
    snap.servo_a = pins[CH_SERVO_A];
    snap.servo_b = pins[CH_SERVO_B];
    snap.ping    = pins[CH_PING0 +: NUM_PING];
    snap.camera  = pins[CH_CAMERA];
    snap.led     = alarm;
    snap.siren   = pins[CH_SIREN];
    return snap;
  endfunction

  function automatic void note_field(string field, logic [2:0] want, logic [2:0] got);
    if (got !== want) begin
      faults++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    end
  endfunction

  always @(posedge clk) begin : watch
    pin_snap_t want;
    if (!rst_n) begin
      for (int i = 0; i < NUM_CH; i++) begin
        phase_reg[i] = REG_RESET[i];
        last_flip[i] = '0;
        hold_len[i]  = '0;
        rise_next[i] = 1'b0;
      end
      pins = '0;
      level_q.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready && cfg_mon.index < NUM_CH)
        phase_reg[cfg_mon.index] = cfg_mon.data;
      if (out_mon.valid && out_mon.ready) begin
        if (level_q.size() == 0) begin
          faults++;
          $display("%0t: unexpected result beat, expected none, got %b %b %b %b %b %b",
                   $time, out_mon.servo_a_level, out_mon.servo_b_level,
                   out_mon.ping_levels, out_mon.camera_level, out_mon.alarm_led,
                   out_mon.siren_level);
        end else begin
          want = level_q.pop_front();
          checked++;
          note_field("servo_a_level", want.servo_a, out_mon.servo_a_level);
          note_field("servo_b_level", want.servo_b, out_mon.servo_b_level);
          note_field("ping_levels",   want.ping,    out_mon.ping_levels);
          note_field("camera_level",  want.camera,  out_mon.camera_level);
          note_field("alarm_led",     want.led,     out_mon.alarm_led);
          note_field("siren_level",   want.siren,   out_mon.siren_level);
        end
      end
      if (in_mon.valid && in_mon.ready)
        level_q.push_back(tick_levels(in_mon.current_time, in_mon.direction,
                                      in_mon.ping_enable, in_mon.alarm_active,
                                      in_mon.siren_switch));
    end
    fault_count   <= faults;
    pending_count <= level_q.size();
    checked_count <= checked;
  end

endmodule

// ----- verif/multichannel_pulse_timer_test.sv -----
// Top of the multichannel pulse timer testbench: makes ticks, register writes and
// back-pressure, and prints the verdict. Prediction lives in the checker module.
// Depends on mpt_pkg, the three channel interfaces, the DUT and the checker.
module multichannel_pulse_timer_test;
  import mpt_pkg::*;

  localparam int        CYCLE_LIMIT  = 400000;
  localparam int        HOLD_CYCLES  = 300;  // long output hold that backs up the input
  localparam int        PHASE_TICKS  = 92;
  localparam int        SETTLE       = 4;    // extra wait at the end of a drain
  localparam reg_addr_t REG_UNMAPPED = 3'd7; // writes here must be dropped
  // direction codes above stop: servos must treat them as stop
  localparam dir_code_t DIR_SPARE_5  = 3'd5;
  localparam dir_code_t DIR_SPARE_6  = 3'd6;
  localparam dir_code_t DIR_SPARE_7  = 3'd7;
  // traffic mixes: none, sender idle, receiver stalls, both
  localparam int SEND_IDLE  [4] = '{0, 60, 0, 24};
  localparam int RECV_STALL [4] = '{0, 0, 60, 24};

  typedef enum int {
    SET_DEFAULT, SET_TINY, SET_ZERO, SET_MAX, SET_MIXED, SET_COUNT
  } reg_set_t;

  typedef struct {
    stamp_t    stamp;
    dir_code_t dir;
    logic      ping_on;
    logic      alarm;
    logic      siren_sw;
  } tick_t;

  logic   clk;
  logic   rst_n;
  int     send_idle_pct = 0;
  int     stall_pct     = 0;
  int     hold_ticket   = 0;  // bumped by the stimulus to request a long hold
  int     ticks_sent    = 0;
  int     reg_writes    = 0;
  int     cycles;
  stamp_t now_stamp;
  int     fault_count;
  int     pending_count;
  int     checked_count;

  mpt_in_if  in_bus ();
  mpt_out_if out_bus ();
  mpt_cfg_if cfg_bus ();

  multichannel_pulse_timer DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  multichannel_pulse_timer_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_bus),
    .out_mon       (out_bus),
    .cfg_mon       (cfg_bus),
    .fault_count   (fault_count),
    .pending_count (pending_count),
    .checked_count (checked_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side. Random stalls at the current mix; a new hold_ticket value starts
  // a long hold counted here, so the sender keeps offering into a full block.
  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_ticket != hold_seen) begin
        hold_seen = hold_ticket;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Watchdog: a run that never drains ends here.
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("%0t: run exceeded %0d cycles, %0d results still due", $time, CYCLE_LIMIT,
             pending_count);
    $display("CHECKS FAILED");
    $finish;
  end

  // One tick beat. Idle cycles come first so valid is never dropped and raised
  // in the same step; valid stays high after accept until the next call decides.
  task automatic send_tick(tick_t tk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid        <= 1'b1;
    in_bus.current_time <= tk.stamp;
    in_bus.direction    <= tk.dir;
    in_bus.ping_enable  <= tk.ping_on;
    in_bus.alarm_active <= tk.alarm;
    in_bus.siren_switch <= tk.siren_sw;
    do @(posedge clk); while (!in_bus.ready);
    ticks_sent++;
  endtask

  // Caller lowers cfg valid after its last write.
  task automatic write_reg(reg_addr_t idx, len_t val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk); while (!cfg_bus.ready);
    reg_writes++;
  endtask

  // Stop sending and wait for every result; registers may only change after this.
  task automatic drain();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Writes all seven lengths for one setting; span scales the big time steps
  // so the longest phases still toggle now and then.
  task automatic load_setting(reg_set_t which, output int span);
    len_t val;
    int   longest;
    longest = 0;
    for (int i = 0; i < NUM_CH; i++) begin
      case (which)
        SET_DEFAULT: val = REG_RESET[i];
        SET_TINY:    val = len_t'($urandom_range(12));
        SET_ZERO:    val = '0;
        SET_MAX:     val = '1;
        default: begin
          case ($urandom_range(3))
            0:       val = '0;
            1:       val = '1;
            2:       val = len_t'($urandom_range(64));
            default: val = len_t'($urandom);
          endcase
        end
      endcase
      write_reg(reg_addr_t'(i), val);
      if (int'(val) > longest) longest = int'(val);
    end
    if ($urandom_range(1) == 1) write_reg(REG_UNMAPPED, len_t'($urandom));
    cfg_bus.valid <= 1'b0;
    span = longest / 2 + 16;
  endtask

  // Mostly forward steps on four scales, with the odd jump anywhere (which
  // also lands behind the last toggle and looks like a huge elapsed time).
  function automatic tick_t random_tick(int span);
    tick_t tk;
    case ($urandom_range(3))
      0:       now_stamp += $urandom_range(8);
      1:       now_stamp += $urandom_range(256);
      2:       now_stamp += $urandom_range(4096);
      default: now_stamp += $urandom_range(span);
    endcase
    if ($urandom_range(24) == 0) now_stamp = $urandom;
    tk.stamp    = now_stamp;
    tk.dir      = ($urandom_range(9) == 0) ?
                  dir_code_t'($urandom_range(DIR_SPARE_7, DIR_SPARE_5)) :
                  dir_code_t'($urandom_range(DIR_STOP));
    tk.ping_on  = ($urandom_range(99) < 85);
    tk.alarm    = ($urandom_range(99) < 70);
    tk.siren_sw = ($urandom_range(99) < 60);
    return tk;
  endfunction

  initial begin
    int span;
    in_bus.valid        = 1'b0;
    in_bus.current_time = '0;
    in_bus.direction    = DIR_RIGHT;
    in_bus.ping_enable  = 1'b0;
    in_bus.alarm_active = 1'b0;
    in_bus.siren_switch = 1'b0;
    cfg_bus.valid       = 1'b0;
    cfg_bus.index       = REG_SERVO_LONG_HIGH;
    cfg_bus.data        = '0;
    now_stamp           = '0;
    rst_n               = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: short lengths so a few ticks walk every channel through
    // both levels; zero length toggles on any advance of the stamp.
    write_reg(REG_SERVO_LONG_HIGH,  17'd6);
    write_reg(REG_SERVO_SHORT_HIGH, 17'd3);
    write_reg(REG_SERVO_LOW,        17'd2);
    write_reg(REG_PING_HIGH,        17'd0);
    write_reg(REG_PING_LOW,         17'd1);
    write_reg(REG_CAMERA_HALF,      17'd4);
    write_reg(REG_SIREN_HALF,       17'd0);
    write_reg(REG_UNMAPPED,         17'h1FFFF);
    cfg_bus.valid <= 1'b0;

    send_tick('{32'd0,   DIR_RIGHT,    1'b1, 1'b1, 1'b1}); // elapsed equals length: hold
    send_tick('{32'd1,   DIR_RIGHT,    1'b1, 1'b1, 1'b1}); // first toggle goes low
    send_tick('{32'd4,   DIR_RIGHT,    1'b1, 1'b1, 1'b1});
    send_tick('{32'd5,   DIR_LEFT,     1'b1, 1'b1, 1'b1});
    send_tick('{32'd9,   DIR_LEFT,     1'b1, 1'b1, 1'b1});
    send_tick('{32'd12,  DIR_FORWARD,  1'b1, 1'b1, 1'b1});
    send_tick('{32'd20,  DIR_FORWARD,  1'b1, 1'b1, 1'b1});
    send_tick('{32'd24,  DIR_BACKWARD, 1'b1, 1'b1, 1'b1});
    send_tick('{32'd32,  DIR_BACKWARD, 1'b1, 1'b1, 1'b1});
    send_tick('{32'd40,  DIR_STOP,     1'b1, 1'b1, 1'b1}); // servos frozen
    send_tick('{32'd60,  DIR_SPARE_5,  1'b0, 1'b1, 1'b1}); // ping channels hold
    send_tick('{32'd80,  DIR_SPARE_6,  1'b0, 1'b1, 1'b0}); // switch off: siren low
    send_tick('{32'd100, DIR_SPARE_7,  1'b1, 1'b0, 1'b1}); // alarm off: cam, siren low
    send_tick('{32'd101, DIR_RIGHT,    1'b1, 1'b0, 1'b0});
    send_tick('{32'd110, DIR_RIGHT,    1'b1, 1'b1, 1'b1}); // gated channels resume
    send_tick('{32'hFFFF_FFF0, DIR_RIGHT,    1'b1, 1'b1, 1'b1});
    send_tick('{32'hFFFF_FFFF, DIR_LEFT,     1'b1, 1'b1, 1'b1});
    send_tick('{32'h0000_0003, DIR_RIGHT,    1'b1, 1'b1, 1'b1}); // wrap through zero
    send_tick('{32'h0000_0003, DIR_FORWARD,  1'b1, 1'b1, 1'b1}); // same stamp again
    send_tick('{32'h7FFF_FFFF, DIR_BACKWARD, 1'b1, 1'b1, 1'b1});
    send_tick('{32'h8000_0000, DIR_RIGHT,    1'b1, 1'b1, 1'b1});
    send_tick('{32'h0000_0010, DIR_LEFT,     1'b1, 1'b1, 1'b1}); // stamp steps back
    drain();

    // Random part: every register setting under every traffic mix. Each phase
    // ends with a full drain, so registers only change while the block is idle.
    for (int s = 0; s < SET_COUNT; s++) begin
      for (int m = 0; m < 4; m++) begin
        load_setting(reg_set_t'(s), span);
        send_idle_pct = SEND_IDLE[m];
        stall_pct    <= RECV_STALL[m];
        now_stamp     = $urandom;
        for (int k = 0; k < PHASE_TICKS; k++) begin
          // long hold with the sender flat out: both stages fill, input stalls
          if (s == SET_TINY && m == 0 && k == 30) hold_ticket <= hold_ticket + 1;
          send_tick(random_tick(span));
        end
        drain();
      end
    end

    repeat (2 * SETTLE) @(posedge clk);
    $display("Summary: %0d ticks, %0d register writes, %0d result beats compared",
             ticks_sent, reg_writes, checked_count);
    $display("Summary: all directions, gating, stamp wrap, five length sets, %0d-cycle hold",
             HOLD_CYCLES);
    if (fault_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
